/* rtl/core/frfc_pkg.sv */
`timescale 1ns / 1ps

package frfc_pkg;

	localparam int DEF_ADDR_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	// FASTA characters of interest
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam logic [15:0] SEQ_LEN_MAX = 16'hFFFF;

	// register select, taken from paddr[2]
	localparam logic REG_BASE_ADDR   = 1'b0;
	localparam logic REG_MIN_SEQ_LEN = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic [7:0] next_byte;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [31:0] write_addr;
		logic [7:0]  write_byte;
		logic        record_start;
		logic        seq_start_mark;
		logic        drop_record;
		logic [31:0] record_count;
		logic [31:0] removed_count;
		logic [31:0] end_addr;
	} out_word_t;

	typedef struct packed {
		logic        base_load;
		logic [31:0] base_addr;
		logic [15:0] min_seq_len;
	} cfg_t;

endpackage

/* rtl/core/frfc_cfg.sv */
`timescale 1ns / 1ps

module frfc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [frfc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output frfc_pkg::cfg_t                      cfg
);
	import frfc_pkg::*;

	logic [31:0] base_q;
	logic [15:0] min_len_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			min_len_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BASE_ADDR:   base_q    <= pwdata;
				REG_MIN_SEQ_LEN: min_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BASE_ADDR:   prdata = base_q;
			REG_MIN_SEQ_LEN: prdata = {16'h0000, min_len_q};
			default:         prdata = '0;
		endcase
	end

	// base write also reloads the byte index, same data as the register
	assign cfg.base_load   = wr_en && (paddr[2] == REG_BASE_ADDR);
	assign cfg.base_addr   = pwdata;
	assign cfg.min_seq_len = min_len_q;

endmodule

/* rtl/core/frfc_core.sv */
`timescale 1ns / 1ps

module frfc_core #(
	parameter int ADDR_BITS = frfc_pkg::DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frfc_pkg::cfg_t       cfg,
	input  logic                 step,
	input  frfc_pkg::in_word_t   item,
	output frfc_pkg::out_word_t  res
);
	import frfc_pkg::*;

	localparam int A = ADDR_BITS;

	logic         in_header_q, in_seq_q;
	logic [15:0]  seq_len_q;
	logic [A-1:0] removed_q, header_q, body_q, byte_idx_q;
	logic [31:0]  kept_q;

	logic         n_in_header, n_in_seq;
	logic [15:0]  n_seq_len;
	logic [A-1:0] n_removed, n_header, n_body;
	logic [31:0]  n_kept;
	logic [A-1:0] idx, fin_body, end_a;
	logic         rec_start, seq_mark, dropped;

	always_comb begin
		idx         = byte_idx_q - removed_q;
		n_in_header = in_header_q;
		n_in_seq    = in_seq_q;
		n_seq_len   = seq_len_q;
		n_removed   = removed_q;
		n_header    = header_q;
		n_body      = body_q;
		n_kept      = kept_q;
		rec_start   = 1'b0;
		seq_mark    = 1'b0;
		dropped     = 1'b0;
		fin_body    = '0;
		end_a       = '0;

		case (item.in_byte)
			CH_GT: begin
				rec_start   = 1'b1;
				n_header    = idx;
				n_seq_len   = '0;
				n_in_header = 1'b1;
				n_in_seq    = 1'b0;
				n_kept      = kept_q + 32'd1;
			end
			CH_LF: begin
				if (in_header_q && !item.last) begin
					seq_mark    = 1'b1;
					n_body      = idx + A'(1);
					n_in_header = 1'b0;
					n_in_seq    = 1'b1;
				end else if (in_seq_q && !item.last) begin
					if (item.next_byte != CH_GT) begin
						n_removed = removed_q + A'(1);
					end else if (seq_len_q < cfg.min_seq_len) begin
						// short record: rewind to its header
						if (seq_len_q != SEQ_LEN_MAX)
							n_seq_len = seq_len_q + 16'd1;
						n_removed   = removed_q + A'(n_seq_len) + (body_q - header_q);
						n_kept      = kept_q - 32'd1;
						dropped     = 1'b1;
						n_in_header = 1'b0;
						n_in_seq    = 1'b0;
					end
				end
			end
			CH_STAR: begin
				if (in_seq_q)
					n_removed = removed_q + A'(1);
			end
			default: begin
				if (in_seq_q && seq_len_q != SEQ_LEN_MAX)
					n_seq_len = seq_len_q + 16'd1;
			end
		endcase

		if (item.last) begin
			if ((n_in_header || n_in_seq) && n_seq_len < cfg.min_seq_len) begin
				// open record at end of chunk, also drops the newline before it
				fin_body    = n_in_header ? (idx + A'(1)) : n_body;
				n_removed   = n_removed + A'(n_seq_len) + (fin_body - n_header) + A'(1);
				n_kept      = n_kept - 32'd1;
				dropped     = 1'b1;
				n_in_header = 1'b0;
				n_in_seq    = 1'b0;
			end
			end_a = byte_idx_q - n_removed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b0;
			in_seq_q    <= 1'b0;
			seq_len_q   <= '0;
			removed_q   <= '0;
			header_q    <= '0;
			body_q      <= '0;
			kept_q      <= '0;
			byte_idx_q  <= '0;
		end else if (cfg.base_load) begin
			byte_idx_q <= A'(cfg.base_addr);
		end else if (step) begin
			in_header_q <= n_in_header;
			in_seq_q    <= n_in_seq;
			seq_len_q   <= n_seq_len;
			removed_q   <= n_removed;
			header_q    <= n_header;
			body_q      <= n_body;
			kept_q      <= n_kept;
			byte_idx_q  <= byte_idx_q + A'(1);
		end
	end

	assign res.write_addr     = 32'(idx);
	assign res.write_byte     = item.in_byte;
	assign res.record_start   = rec_start;
	assign res.seq_start_mark = seq_mark;
	assign res.drop_record    = dropped;
	assign res.record_count   = n_kept;
	assign res.removed_count  = 32'(n_removed);
	assign res.end_addr       = 32'(end_a);

	a_state_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_header_q && in_seq_q))
		else $error("header and sequence both open");

	a_end_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.last |-> res.end_addr == 32'd0)
		else $error("end address given on a non-final byte");

	a_mark_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.seq_start_mark |-> !res.record_start && !res.drop_record)
		else $error("sequence mark together with record start or drop");

	a_drop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.drop_record |=> !in_header_q && !in_seq_q)
		else $error("record still open after a drop");

endmodule

/* rtl/core/fasta_record_filter_compactor.sv */
`timescale 1ns / 1ps
// Path: an accepted word is held in the input register; when it advances, its result is
//   registered in the result register. A full result register that is not taken stalls it.
// Throughput: one word per cycle while each result is taken; the whole per-byte state update
//   is one compare-and-add pass between the input register and the result register.
// Reset (arst_n low, asynchronous): all parser state, counters and both configuration
//   registers clear, byte index returns to 0, no word is held on either side.
module fasta_record_filter_compactor #(
	parameter int ADDR_BITS = frfc_pkg::DEF_ADDR_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [frfc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// byte stream in
	input  logic                                item_valid,
	output logic                                item_ready,
	input  frfc_pkg::in_word_t                  item,
	// compacted stream out
	output logic                                res_valid,
	input  logic                                res_ready,
	output frfc_pkg::out_word_t                 res
);
	import frfc_pkg::*;

	cfg_t      cfg;
	in_word_t  item_s1;
	logic      valid_s1;
	out_word_t core_res;
	out_word_t res_q;
	logic      res_valid_q;
	logic      advance;

	frfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The input register moves into the core when the result register is
	// empty or being drained this cycle; the state update happens on that edge.
	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	frfc_core #(
		.ADDR_BITS (ADDR_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.res    (core_res)
	);

	// result register: holds a finished word while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && res_valid_q && !res_ready)
		else $error("input stalled with nothing to hold it");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !res_valid_q || res_ready)
		else $error("result register overwritten before it was taken");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advanced word did not reach the result register");

endmodule
